// File: rtl/sorted_priority_queue_macros.svh
// Assertion macros used by the checks in the queue's top-level file.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("queue check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("queue check failed one cycle later");

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              fire;
        logic [OP_W-1:0]   op;
        logic              ins_ok;
        logic              desc;
        logic [POS_W-1:0]  from_pos;
        logic [POS_W-1:0]  to_pos;
    } cmd_t;

    // Flags a cell hands to its neighbors. The gt flag is set when some held key at or
    // before the cell compares greater than the request key; the ge flag is set when the
    // find scan has already stopped at or before the cell.
    typedef struct packed {
        logic valid;
        logic gt;
        logic ge;
    } nbr_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell import spq_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int DEPTH     = DEPTH_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    input  logic [KEY_WIDTH-1:0] key_in,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  nbr_t                 left,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  nbr_t                 right,
    output logic [KEY_WIDTH-1:0] key_q,
    output nbr_t                 self,
    output logic                 ins_spot,
    output logic                 find_hit
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
    localparam logic [CW-1:0] ME = CW'(CELL_IDX);

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 valid_reg, valid_next;
    logic                 gt, kgt, ge, in_range, first;
    logic [CW-1:0]        from_x, to_x;

    // The held key compares greater than the request key, and the other way round.
    assign gt  = valid_reg & (cmd.desc ? (key_reg < key_in) : (key_reg > key_in));
    assign kgt = cmd.desc ? (key_in < key_reg) : (key_in > key_reg);
    assign ge  = valid_reg & ~kgt;

    // The flags accumulate along the row, since the held keys need not be in order
    // once the direction has changed.
    assign self  = '{valid: valid_reg, gt: left.gt | gt, ge: left.ge | (ge & in_range)};
    assign key_q = key_reg;

    // First greater key, or the first free cell when no held key is greater.
    assign ins_spot = (gt & ~left.gt) | (~valid_reg & left.valid & ~left.gt);

    assign from_x   = CW'(cmd.from_pos);
    assign to_x     = CW'(cmd.to_pos);
    assign in_range = (ME >= from_x) && (ME < to_x);
    // The scan stops at the first key in range that the request key does not exceed.
    assign first    = ge & in_range & ~left.ge;
    assign find_hit = first & (key_reg == key_in);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (cmd.fire) begin
            case (cmd.op)
                OP_INSERT: begin
                    if (cmd.ins_ok) begin
                        if (ins_spot) begin
                            key_next = key_in;
                        end else if (left.gt) begin
                            key_next = left_key;
                        end
                        valid_next = valid_reg | left.valid;
                    end
                end
                OP_POP_FRONT: begin
                    key_next   = right_key;
                    valid_next = right.valid;
                end
                OP_POP_BACK: begin
                    valid_next = valid_reg & right.valid;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// File: rtl/spq_select.sv
module spq_select import spq_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int DEPTH     = DEPTH_DEF,
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic [DEPTH-1:0]     pos_onehot,
    input  logic [DEPTH-1:0]     last_onehot,
    input  logic [KEY_WIDTH-1:0] keys [DEPTH],
    output logic [IDX_W-1:0]     pos_idx,
    output logic [KEY_WIDTH-1:0] last_key
);

    // Both inputs carry at most one set bit, so an OR of the selected terms suffices.
    always_comb begin
        pos_idx  = '0;
        last_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos_onehot[i]) begin
                pos_idx = pos_idx | IDX_W'(i);
            end
            if (last_onehot[i]) begin
                last_key = last_key | keys[i];
            end
        end
    end

endmodule

// File: rtl/sorted_priority_queue.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  opcode, key, start_pos, end_pos
// m_axis    out        m_axis_tvalid / m_axis_tready  status, key_out, position, count
// cfg       in         cfg_wr_en                      descending_order
//
// The row of cells compares and shifts in the cycle a request is accepted, and the
// result lands in the output register at the edge that ends that cycle.
// A new request is accepted whenever the output register is empty or is being taken
// in the same cycle, so requests can follow each other without gaps.
// Reset is synchronous and active low; it empties the queue and sets ascending order.
// A stall on the result side holds the result and stops new requests.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int DATA_W   = ((KEY_WIDTH + OP_W + 2 * POS_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,   // descending_order
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // opcode, key, start_pos, end_pos
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata   // status, key_out, position, count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) > POS_W
                           ? ((IDX_W > CNT_W) ? IDX_W : CNT_W) : POS_W;

    // Request fields, unpacked from the lowest bit up.
    logic [OP_W-1:0]      req_op;
    logic [KEY_WIDTH-1:0] req_key;
    logic [POS_W-1:0]     req_from, req_to;

    assign req_op   = s_axis_tdata[OP_W-1:0];
    assign req_key  = s_axis_tdata[OP_W +: KEY_WIDTH];
    assign req_from = s_axis_tdata[OP_W + KEY_WIDTH +: POS_W];
    assign req_to   = s_axis_tdata[OP_W + KEY_WIDTH + POS_W +: POS_W];

    logic                 desc_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [KEY_WIDTH-1:0] key_out_reg, key_out_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     count_reg;

    logic s_accept, full, empty, found;
    cmd_t cmd;

    // The output register parts the two sides; it frees up in the cycle it is taken.
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);

    assign cmd = '{fire: s_accept, op: req_op, ins_ok: ~full, desc: desc_reg,
                   from_pos: req_from, to_pos: req_to};

    // The chain of cells. Cell 0 sees a valid, never-greater neighbor on its left
    // so that an insert into an empty queue lands there; the last cell sees an
    // empty neighbor on its right so that pops clear it.
    logic [KEY_WIDTH-1:0] cell_key [DEPTH];
    nbr_t                 cell_nbr [DEPTH];
    logic [DEPTH-1:0]     ins_vec, hit_vec, last_vec, valid_vec;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_WIDTH-1:0] lk, rk;
            nbr_t                 ln, rn;
            if (g == 0) begin : g_head
                assign lk = '0;
                assign ln = '{valid: 1'b1, gt: 1'b0, ge: 1'b0};
            end else begin : g_mid_l
                assign lk = cell_key[g-1];
                assign ln = cell_nbr[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign rk = '0;
                assign rn = '{valid: 1'b0, gt: 1'b0, ge: 1'b0};
            end else begin : g_mid_r
                assign rk = cell_key[g+1];
                assign rn = cell_nbr[g+1];
            end

            spq_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .DEPTH     (DEPTH),
                .CELL_IDX  (g)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .key_in    (req_key),
                .left_key  (lk),
                .left      (ln),
                .right_key (rk),
                .right     (rn),
                .key_q     (cell_key[g]),
                .self      (cell_nbr[g]),
                .ins_spot  (ins_vec[g]),
                .find_hit  (hit_vec[g])
            );

            assign valid_vec[g] = cell_nbr[g].valid;
            // The last held key sits where a valid cell meets an empty one.
            assign last_vec[g]  = cell_nbr[g].valid & ~rn.valid;
        end
    endgenerate

    logic [IDX_W-1:0]     sel_idx;
    logic [KEY_WIDTH-1:0] back_key;
    logic [EXT_W-1:0]     idx_ext, cnt_ext, cnt_next_ext;

    spq_select #(
        .KEY_WIDTH (KEY_WIDTH),
        .DEPTH     (DEPTH)
    ) u_select (
        .pos_onehot  ((req_op == OP_INSERT) ? ins_vec : hit_vec),
        .last_onehot (last_vec),
        .keys        (cell_key),
        .pos_idx     (sel_idx),
        .last_key    (back_key)
    );

    assign found        = |hit_vec;
    assign idx_ext      = EXT_W'(sel_idx);
    assign cnt_ext      = EXT_W'(cnt_reg);
    assign cnt_next_ext = EXT_W'(cnt_next);

    // Result of the request being accepted, and the count it leaves behind.
    always_comb begin
        status_next  = ST_OK;
        key_out_next = '0;
        pos_next     = '0;
        cnt_next     = cnt_reg;
        if (req_op == OP_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
                pos_next    = cnt_ext[POS_W-1:0];
            end else begin
                key_out_next = req_key;
                pos_next     = idx_ext[POS_W-1:0];
                cnt_next     = cnt_reg + CNT_W'(1);
            end
        end else if (req_op inside {OP_POP_FRONT, OP_POP_BACK}) begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                key_out_next = (req_op == OP_POP_FRONT) ? cell_key[0] : back_key;
                cnt_next     = cnt_reg - CNT_W'(1);
            end
        end else begin
            // Find: a match can only be equal to the request key.
            if (found) begin
                key_out_next = req_key;
                pos_next     = idx_ext[POS_W-1:0];
            end else begin
                status_next = ST_NOT_FOUND;
                pos_next    = req_to;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                desc_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it is only loaded when a request is accepted.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            status_reg  <= status_next;
            key_out_reg <= key_out_next;
            pos_reg     <= pos_next;
            count_reg   <= cnt_next_ext[POS_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'({count_reg, pos_reg, key_out_reg, status_reg});

    // The valid cells always form a run as long as the count.
    `SPQ_ASSERT_IMPLY(a_valid_matches_count, aclk, aresetn, 1'b1, $countones(valid_vec) == int'(cnt_reg))
    // An insert into a queue that has room grows it by one.
    `SPQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, s_accept && (req_op == OP_INSERT) && !full, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    // Every accepted request leaves a result waiting in the next cycle.
    `SPQ_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept, m_axis_tvalid)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH  = DEPTH_DEF;
    localparam int KEY_W  = KEY_WIDTH_DEF;
    localparam int DATA_W = ((KEY_W + OP_W + 2 * POS_W + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - (KEY_W + OP_W + 2 * POS_W);

    // The run is cut off here if the queue hangs.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Random traffic is split into segments. Each segment changes the sort direction, and
    // each pair of segments changes the idling pattern.
    localparam int SEGMENTS         = 6;
    localparam int REQS_PER_SEGMENT = 185;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [POS_W-1:0] pos_t;

    // A request as it travels on s_axis_tdata. The last field sits in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        pos_t             end_pos;
        pos_t             start_pos;
        key_t             key;
        logic [OP_W-1:0]  op;
    } request_t;

    // A result as it travels on m_axis_tdata.
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        pos_t             count;
        pos_t             position;
        key_t             key_out;
        logic [ST_W-1:0]  status;
    } outcome_t;

    // The tracker mirrors the queue contents and the sort direction. It turns every
    // accepted request into the result the block must return, and checks results in order.
    class queue_tracker;
        key_t     held[DEPTH];
        int       held_count;
        bit       descending;
        outcome_t awaited[$];
        int       mismatches;
        int       results_seen;

        function new();
            held_count   = 0;
            descending   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            foreach (held[i]) held[i] = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // True when a sorts after b in the current direction.
        function bit sorts_after(key_t a, key_t b);
            return descending ? (a < b) : (a > b);
        endfunction

        // Applies one request to the mirrored queue and returns its result.
        function outcome_t apply_request(request_t r);
            outcome_t o;
            int       at;
            int       lim;
            int       i;
            bit       stop;
            o = '0;
            case (r.op)
                OP_INSERT: begin
                    if (held_count >= DEPTH) begin
                        o.status   = ST_FULL;
                        o.position = pos_t'(held_count);
                    end else begin
                        at   = held_count;
                        stop = 1'b0;
                        for (i = 0; i < held_count && !stop; i++) begin
                            if (sorts_after(held[i], r.key)) begin
                                at   = i;
                                stop = 1'b1;
                            end
                        end
                        for (i = held_count; i > at; i--) held[i] = held[i-1];
                        held[at] = r.key;
                        held_count++;
                        o.status   = ST_OK;
                        o.key_out  = r.key;
                        o.position = pos_t'(at);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (held_count == 0) begin
                        o.status = ST_EMPTY;
                    end else begin
                        if (r.op == OP_POP_FRONT) begin
                            o.key_out = held[0];
                            for (i = 1; i < held_count; i++) held[i-1] = held[i];
                        end else begin
                            o.key_out = held[held_count-1];
                        end
                        held_count--;
                        o.status = ST_OK;
                    end
                end
                default: begin
                    lim        = (int'(r.end_pos) < held_count) ? int'(r.end_pos) : held_count;
                    o.status   = ST_NOT_FOUND;
                    o.position = r.end_pos;
                    stop       = 1'b0;
                    for (i = int'(r.start_pos); i < lim && !stop; i++) begin
                        if (!sorts_after(r.key, held[i])) begin
                            stop = 1'b1;
                            if (held[i] == r.key) begin
                                o.status   = ST_OK;
                                o.key_out  = held[i];
                                o.position = pos_t'(i);
                            end
                        end
                    end
                end
            endcase
            o.count = pos_t'(held_count);
            return o;
        endfunction

        function void note_request(request_t r);
            awaited.push_back(apply_request(r));
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH: %s", what);
        endtask

        task check_field(string field, longint unsigned got, longint unsigned want);
            if (got != want)
                flag_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                        results_seen, field, got, want));
        endtask

        task check_result(outcome_t got);
            outcome_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with no request waiting",
                                        results_seen));
            end else begin
                want = awaited.pop_front();
                check_field("status", got.status, want.status);
                check_field("key_out", got.key_out, want.key_out);
                check_field("position", got.position, want.position);
                check_field("count", got.count, want.count);
            end
        endtask
    endclass

    // Every input of the block holds a known value from time zero.
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic              cfg_wr_data   = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;

    queue_tracker tracker;
    int unsigned  cycle_count   = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           filling       = 1'b1;
    key_t         key_pool[6];

    sorted_priority_queue DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Result side. All drives are nonblocking, so the values read here at the rising edge
    // are the ones the block saw at that edge. A result counts when valid and ready were
    // both high. Ready is redrawn every cycle to stall the block at random.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end

    function automatic request_t make_request(logic [OP_W-1:0] op, key_t key,
                                              int start_pos, int end_pos);
        request_t r;
        r           = '0;
        r.op        = op;
        r.key       = key;
        r.start_pos = pos_t'(start_pos);
        r.end_pos   = pos_t'(end_pos);
        return r;
    endfunction

    // Offers one request, after a random number of idle cycles, and holds it until the
    // block takes it. Returns at the edge that accepted the request.
    task automatic send_request(request_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.note_request(r);
    endtask

    // Stops offering requests and waits until every expected result has been taken.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // The direction register may only change while the block holds no request in flight.
    // The held keys stay where they are, so the queue may be out of order afterwards.
    task automatic set_direction(bit descending);
        wait_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= descending;
        @(posedge aclk);
        cfg_wr_en          <= 1'b0;
        tracker.descending  = descending;
    endtask

    // Keys are drawn often from a small pool so that duplicates, exact finds and near
    // misses happen regularly. The pool always holds the two extreme keys.
    function automatic key_t pick_key();
        if ($urandom_range(0, 9) < 4) return key_pool[$urandom_range(0, 5)];
        return key_t'($urandom);
    endfunction

    function automatic request_t random_request(bit fill_bias);
        request_t r;
        int       pick;
        int       held;
        held = tracker.held_count;
        pick = $urandom_range(0, 99);
        r    = '0;
        // Filling favors inserts until the queue runs full; draining favors pops and finds
        // until it runs empty. This walks the count over its whole range again and again.
        if (fill_bias)
            r.op = (pick < 55) ? OP_INSERT : (pick < 65) ? OP_POP_FRONT :
                   (pick < 75) ? OP_POP_BACK : OP_FIND;
        else
            r.op = (pick < 15) ? OP_INSERT : (pick < 35) ? OP_POP_FRONT :
                   (pick < 55) ? OP_POP_BACK : OP_FIND;
        r.key = pick_key();
        if (r.op == OP_FIND && held != 0 && $urandom_range(0, 1) == 1)
            r.key = tracker.held[$urandom_range(0, held - 1)];
        // Most finds search a sensible window; the rest take any start and end, including
        // empty windows and windows that run past the held keys.
        if ($urandom_range(0, 9) < 7) begin
            r.start_pos = pos_t'($urandom_range(0, held));
            r.end_pos   = pos_t'($urandom_range(int'(r.start_pos), DEPTH));
        end else begin
            r.start_pos = pos_t'($urandom_range(0, DEPTH));
            r.end_pos   = pos_t'($urandom_range(0, DEPTH));
        end
        return r;
    endfunction

    // Directed requests in ascending order: pops and a find on the empty queue, the two
    // extreme keys, a duplicate key, finds that hit, miss, search an empty window or run
    // past the held keys, then a fill up to the limit and one insert into the full queue.
    task automatic run_directed();
        send_request(make_request(OP_POP_FRONT, '0, 0, 0));
        send_request(make_request(OP_POP_BACK, '1, 16, 16));
        send_request(make_request(OP_FIND, '0, 0, 16));
        send_request(make_request(OP_INSERT, '0, 0, 0));
        send_request(make_request(OP_INSERT, '1, 0, 0));
        send_request(make_request(OP_INSERT, 32'd5, 0, 0));
        send_request(make_request(OP_INSERT, 32'd5, 0, 0));
        send_request(make_request(OP_FIND, 32'd5, 0, 16));
        send_request(make_request(OP_FIND, 32'd5, 2, 16));
        send_request(make_request(OP_FIND, 32'd6, 0, 16));
        send_request(make_request(OP_FIND, 32'd5, 3, 1));
        send_request(make_request(OP_FIND, '1, 0, 16));
        send_request(make_request(OP_FIND, '1, 0, 3));
        for (int i = 0; i < DEPTH - 4; i++)
            send_request(make_request(OP_INSERT, 32'hAAAA_AAAA ^ key_t'(i * 32'h0101_0101),
                                      0, 0));
        send_request(make_request(OP_INSERT, 32'd1, 31, 31));
    endtask

    initial begin
        tracker = new();

        // Synchronous reset, active from time zero, released once and never asserted again.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 38;
        recv_idle_pct = 67;
        run_directed();

        // Segments run in pairs: the receiver idles hard in the first pair, the sender in
        // the second, and neither in the last. Each pair covers both sort directions.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_direction(bit'(seg % 2));
            case (seg / 2)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            key_pool[0] = '0;
            key_pool[1] = '1;
            key_pool[2] = key_t'($urandom);
            key_pool[3] = key_pool[2] + 1'b1;
            key_pool[4] = key_t'($urandom_range(0, 15));
            key_pool[5] = key_t'($urandom);
            for (int n = 0; n < REQS_PER_SEGMENT; n++) begin
                send_request(random_request(filling));
                if (tracker.held_count == DEPTH) filling = 1'b0;
                else if (tracker.held_count == 0) filling = 1'b1;
                else if ($urandom_range(0, 99) < 2) filling = !filling;
            end
        end

        // Every request yields exactly one result, waiting in the cycle after it is accepted,
        // so a short wait after the drain is enough to catch any stray result.
        wait_until_drained();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
